// ===== rtl/ppcdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_pkg
// Shared types and opcode constants of the PowerPC subset instruction decoder.
// ----------------------------------------------------------------------------
package ppcdec_pkg;

   typedef enum logic [4:0] {
      OP_NONE   = 5'd0,
      OP_ADDI   = 5'd1,
      OP_ADDIS  = 5'd2,
      OP_RLWINM = 5'd3,
      OP_ORI    = 5'd4,
      OP_B      = 5'd5,
      OP_ANDI   = 5'd6,
      OP_BCLR   = 5'd7,
      OP_CMPWI  = 5'd8,
      OP_BC     = 5'd9,
      OP_MFLR   = 5'd10,
      OP_MTLR   = 5'd11,
      OP_CMPW   = 5'd12,
      OP_ADD    = 5'd13,
      OP_SUBF   = 5'd14,
      OP_OR     = 5'd15,
      OP_AND    = 5'd16,
      OP_XOR    = 5'd17,
      OP_LWZ    = 5'd18,
      OP_LBZ    = 5'd19,
      OP_STW    = 5'd20,
      OP_STWU   = 5'd21,
      OP_STB    = 5'd22,
      OP_LHZ    = 5'd23,
      OP_STH    = 5'd24
   } op_type;

   // primary opcodes
   localparam logic [5:0] PO_CMPI   = 6'd11;
   localparam logic [5:0] PO_ADDI   = 6'd14;
   localparam logic [5:0] PO_ADDIS  = 6'd15;
   localparam logic [5:0] PO_BC     = 6'd16;
   localparam logic [5:0] PO_B      = 6'd18;
   localparam logic [5:0] PO_XL     = 6'd19;
   localparam logic [5:0] PO_RLWINM = 6'd21;
   localparam logic [5:0] PO_ORI    = 6'd24;
   localparam logic [5:0] PO_ANDI   = 6'd28;
   localparam logic [5:0] PO_X      = 6'd31;
   localparam logic [5:0] PO_LWZ    = 6'd32;
   localparam logic [5:0] PO_LBZ    = 6'd34;
   localparam logic [5:0] PO_STW    = 6'd36;
   localparam logic [5:0] PO_STWU   = 6'd37;
   localparam logic [5:0] PO_STB    = 6'd38;
   localparam logic [5:0] PO_LHZ    = 6'd40;
   localparam logic [5:0] PO_STH    = 6'd44;

   // extended opcodes
   localparam logic [9:0] XO_BCLR   = 10'd16;
   localparam logic [9:0] XO_CMP    = 10'd0;
   localparam logic [9:0] XO_AND    = 10'd28;
   localparam logic [9:0] XO_SUBF   = 10'd40;
   localparam logic [9:0] XO_ADD    = 10'd266;
   localparam logic [9:0] XO_XOR    = 10'd316;
   localparam logic [9:0] XO_MFSPR  = 10'd339;
   localparam logic [9:0] XO_OR     = 10'd444;
   localparam logic [9:0] XO_MTSPR  = 10'd467;

   localparam logic [4:0] SprLrLow  = 5'd8;

   // first declared member sits in the highest bits
   typedef struct packed {
      logic [2:0]        crf_index;
      logic [4:0]        bi_field;
      logic [4:0]        bo_field;
      logic [2:0]        flag_bits;
      logic [4:0]        mask_last;
      logic [4:0]        mask_first;
      logic [4:0]        rot_amount;
      logic signed [25:0] imm_value;
      logic [4:0]        src_reg;
      logic [4:0]        base_reg;
      logic [4:0]        dest_reg;
      op_type            op_code;
   } result_type;

endpackage

// ===== rtl/ppcdec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_decode
// Field extraction and opcode classification of one instruction word.
// ----------------------------------------------------------------------------
module ppcdec_decode (
   input  logic [31:0]              instr_word,
   output ppcdec_pkg::result_type   result
);

   logic [5:0]  po;
   logic [9:0]  xo;
   logic [4:0]  f21;
   logic [4:0]  f16;
   logic [4:0]  f11;
   logic [25:0] simm;
   logic [25:0] uimm;

   assign po   = instr_word[31:26];
   assign xo   = instr_word[10:1];
   assign f21  = instr_word[25:21];
   assign f16  = instr_word[20:16];
   assign f11  = instr_word[15:11];
   assign simm = {{10{instr_word[15]}}, instr_word[15:0]};
   assign uimm = {10'd0, instr_word[15:0]};

   always_comb begin
      result = '0;
      unique case (po)
         ppcdec_pkg::PO_ADDI, ppcdec_pkg::PO_ADDIS, ppcdec_pkg::PO_LWZ,
         ppcdec_pkg::PO_LBZ, ppcdec_pkg::PO_STW, ppcdec_pkg::PO_STB,
         ppcdec_pkg::PO_LHZ, ppcdec_pkg::PO_STH: begin
            result.dest_reg  = f21;
            result.base_reg  = f16;
            result.imm_value = simm;
            case (po)
               ppcdec_pkg::PO_ADDI:  result.op_code = ppcdec_pkg::OP_ADDI;
               ppcdec_pkg::PO_ADDIS: result.op_code = ppcdec_pkg::OP_ADDIS;
               ppcdec_pkg::PO_LWZ:   result.op_code = ppcdec_pkg::OP_LWZ;
               ppcdec_pkg::PO_LBZ:   result.op_code = ppcdec_pkg::OP_LBZ;
               ppcdec_pkg::PO_STW:   result.op_code = ppcdec_pkg::OP_STW;
               ppcdec_pkg::PO_STB:   result.op_code = ppcdec_pkg::OP_STB;
               ppcdec_pkg::PO_LHZ:   result.op_code = ppcdec_pkg::OP_LHZ;
               default:              result.op_code = ppcdec_pkg::OP_STH;
            endcase
         end
         ppcdec_pkg::PO_RLWINM: begin
            result.op_code    = ppcdec_pkg::OP_RLWINM;
            result.src_reg    = f21;
            result.dest_reg   = f16;
            result.rot_amount = f11;
            result.mask_first = instr_word[10:6];
            result.mask_last  = instr_word[5:1];
            result.flag_bits  = {2'b00, instr_word[0]};
         end
         ppcdec_pkg::PO_ORI, ppcdec_pkg::PO_ANDI: begin
            result.op_code   = (po == ppcdec_pkg::PO_ORI) ? ppcdec_pkg::OP_ORI
                                                          : ppcdec_pkg::OP_ANDI;
            result.src_reg   = f21;
            result.dest_reg  = f16;
            result.imm_value = uimm;
            result.flag_bits = {2'b00, po == ppcdec_pkg::PO_ANDI};
         end
         ppcdec_pkg::PO_B: begin
            result.op_code   = ppcdec_pkg::OP_B;
            result.imm_value = {instr_word[25:2], 2'b00};
            result.flag_bits = {instr_word[0], instr_word[1], 1'b0};
         end
         ppcdec_pkg::PO_BC: begin
            result.op_code   = ppcdec_pkg::OP_BC;
            result.bo_field  = f21;
            result.bi_field  = f16;
            result.imm_value = {{10{instr_word[15]}}, instr_word[15:2], 2'b00};
            result.flag_bits = {instr_word[0], instr_word[1], 1'b0};
         end
         ppcdec_pkg::PO_XL: begin
            if (xo == ppcdec_pkg::XO_BCLR) begin
               result.op_code   = ppcdec_pkg::OP_BCLR;
               result.bo_field  = f21;
               result.bi_field  = f16;
               result.flag_bits = {instr_word[0], 2'b00};
            end
         end
         ppcdec_pkg::PO_CMPI: begin
            if (!instr_word[21]) begin
               result.op_code   = ppcdec_pkg::OP_CMPWI;
               result.crf_index = instr_word[25:23];
               result.base_reg  = f16;
               result.imm_value = simm;
            end
         end
         ppcdec_pkg::PO_STWU: begin
            result.base_reg = f16;
            if (f16 != 5'd0) begin
               result.op_code   = ppcdec_pkg::OP_STWU;
               result.dest_reg  = f21;
               result.imm_value = simm;
            end
         end
         ppcdec_pkg::PO_X: begin
            case (xo)
               ppcdec_pkg::XO_MFSPR, ppcdec_pkg::XO_MTSPR: begin
                  if (f16 == ppcdec_pkg::SprLrLow && f11 == 5'd0) begin
                     result.op_code  = (xo == ppcdec_pkg::XO_MFSPR) ? ppcdec_pkg::OP_MFLR
                                                                    : ppcdec_pkg::OP_MTLR;
                     result.dest_reg = f21;
                  end
               end
               ppcdec_pkg::XO_CMP: begin
                  if (!instr_word[21]) begin
                     result.op_code   = ppcdec_pkg::OP_CMPW;
                     result.crf_index = instr_word[25:23];
                     result.base_reg  = f16;
                     result.src_reg   = f11;
                  end
               end
               ppcdec_pkg::XO_ADD, ppcdec_pkg::XO_SUBF: begin
                  result.op_code   = (xo == ppcdec_pkg::XO_ADD) ? ppcdec_pkg::OP_ADD
                                                                : ppcdec_pkg::OP_SUBF;
                  result.dest_reg  = f21;
                  result.base_reg  = f16;
                  result.src_reg   = f11;
                  result.flag_bits = {2'b00, instr_word[0]};
               end
               ppcdec_pkg::XO_OR, ppcdec_pkg::XO_AND, ppcdec_pkg::XO_XOR: begin
                  if (xo == ppcdec_pkg::XO_OR) begin
                     result.op_code = ppcdec_pkg::OP_OR;
                  end else if (xo == ppcdec_pkg::XO_AND) begin
                     result.op_code = ppcdec_pkg::OP_AND;
                  end else begin
                     result.op_code = ppcdec_pkg::OP_XOR;
                  end
                  result.src_reg   = f21;
                  result.dest_reg  = f16;
                  result.base_reg  = f11;
                  result.flag_bits = {2'b00, instr_word[0]};
               end
               default: begin
                  result = '0;
               end
            endcase
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== rtl/powerpc_subset_instruction_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// powerpc_subset_instruction_decoder
// Decodes 32-bit PowerPC instruction words into an operation code and fields.
// ----------------------------------------------------------------------------
// One instruction word enters per cycle while the result side is not stalled: the
// word is captured in an input register, decoded by shallow field-extraction
// logic, and the result lands in the output register. Both stages move
// independently, so full throughput holds while rsp_tready is high and a stall
// on the result side backs up one stage at a time.
module powerpc_subset_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // op_code, dest_reg, base_reg, src_reg, imm_value,
                                    // rot_amount, mask_first, mask_last, flag_bits,
                                    // bo_field, bi_field, crf_index, zero pad
);

   logic                   word_valid_ff;
   logic                   word_valid_in;
   logic [31:0]            word_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ppcdec_pkg::result_type rsp_ff;
   ppcdec_pkg::result_type decoded;
   logic                   rsp_load;

   ppcdec_decode u_decode (
      .instr_word (word_ff),
      .result     (decoded)
   );

   assign rsp_load      = word_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !word_valid_ff || rsp_load;
   assign word_valid_in = (req_tvalid && req_tready) || (word_valid_ff && !rsp_load);
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         word_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

`ifndef SYNTH
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_word_moves_on: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid)
      else $error("decoded word not presented");

   a_unknown_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.op_code == ppcdec_pkg::OP_NONE) |->
         (rsp_ff.dest_reg == 5'd0 && rsp_ff.src_reg == 5'd0 &&
          rsp_ff.imm_value == 26'sd0 && rsp_ff.flag_bits == 3'd0 &&
          rsp_ff.crf_index == 3'd0))
      else $error("unrecognised word with nonzero fields");

   a_rotate_fields_only_rlwinm: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_ff.rot_amount != 5'd0 || rsp_ff.mask_first != 5'd0 ||
                      rsp_ff.mask_last != 5'd0)) |->
         (rsp_ff.op_code == ppcdec_pkg::OP_RLWINM))
      else $error("rotate fields set outside rlwinm");
`endif

endmodule
